// File: sv/ttm_pkg.sv
// Shared types and constants for the task timing monitor.
// Used by ttm_ctrl, ttm_dp and task_timing_monitor_core; no dependencies.
`default_nettype none

package ttm_pkg;

   // Field widths
   localparam int TIME_W = 64;
   localparam int STAT_W = 32;
   localparam int FUNC_W = 2;
   localparam int RSP_FIELDS = 9;
   localparam int RSP_W = RSP_FIELDS * STAT_W;
   localparam int REQ_W = 2 * TIME_W;

   // Event kinds carried in req_tuser
   localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_END   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_ADDR = 3'd0;
   localparam int CSR_DATA_W = 32;

   // Divider: two quotient bits per cycle over a 64-bit dividend
   localparam int DIV_CNT_W = 5;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_load;
      logic div_step;
      logic load_out;
   } ttm_cmd_type;

   typedef struct packed {
      logic div_last;
   } ttm_status_type;

endpackage

`default_nettype wire

// File: sv/ttm_ctrl.sv
// Controller of the task timing monitor: sequences capture, update,
// division and result load. Depends on ttm_pkg.
`default_nettype none

module ttm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output ttm_pkg::ttm_cmd_type         cmd,
   input  wire ttm_pkg::ttm_status_type status
);
   import ttm_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_UPDATE   = 3'd1;
   localparam logic [2:0] S_DIV_LOAD = 3'd2;
   localparam logic [2:0] S_DIVIDE   = 3'd3;
   localparam logic [2:0] S_FINISH   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // Output register can take a new item when empty or being drained
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_DIV_LOAD;
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIVIDE;
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/ttm_dp.sv
// Datapath of the task timing monitor: statistics registers, deadline test,
// serial average divider and result register. Depends on ttm_pkg.
`default_nettype none

module ttm_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ttm_pkg::ttm_cmd_type           cmd,
   output ttm_pkg::ttm_status_type             status,
   input  wire logic [ttm_pkg::STAT_W-1:0]     target_period,
   input  wire logic [ttm_pkg::FUNC_W-1:0]     func,
   input  wire logic [ttm_pkg::TIME_W-1:0]     now_time,
   input  wire logic [ttm_pkg::TIME_W-1:0]     run_start_time,
   output logic      [ttm_pkg::RSP_W-1:0]      rsp_data
);
   import ttm_pkg::*;

   // Captured item
   logic [FUNC_W-1:0] func_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] start_ff;

   // Statistics
   logic [TIME_W-1:0] last_wake_ff, last_wake_in;
   logic [STAT_W-1:0] period_low_ff, period_low_in;
   logic [STAT_W-1:0] period_high_ff, period_high_in;
   logic [STAT_W-1:0] misses_ff, misses_in;
   logic [STAT_W-1:0] executions_ff, executions_in;
   logic [TIME_W-1:0] exec_total_ff, exec_total_in;
   logic [STAT_W-1:0] exec_low_ff, exec_low_in;
   logic [STAT_W-1:0] exec_high_ff, exec_high_in;

   // Divider
   logic [STAT_W-1:0]    div_rem_ff;
   logic [TIME_W-1:0]    div_quo_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   logic [RSP_W-1:0] rsp_data_ff;

   logic [STAT_W-1:0] period;
   logic [STAT_W-1:0] run_time;
   logic [STAT_W+3:0] period_x10;
   logic [STAT_W+3:0] target_x11;
   logic              miss;

   logic [STAT_W:0]   rem_a, rem_b, sub_a, sub_b;
   logic              geq_a, geq_b;
   logic [STAT_W-1:0] mid_rem, next_rem;
   logic [TIME_W-1:0] mid_quo, next_quo;

   logic [STAT_W-1:0] exec_avg;
   logic [STAT_W-1:0] period_sum;
   logic [STAT_W-1:0] period_avg;
   logic [STAT_W-1:0] jitter;

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= func;
         now_ff   <= now_time;
         start_ff <= run_start_time;
      end
   end

   // Period, execution time and deadline test
   assign period     = now_ff[STAT_W-1:0] - last_wake_ff[STAT_W-1:0];
   assign run_time   = now_ff[STAT_W-1:0] - start_ff[STAT_W-1:0];
   assign period_x10 = {1'b0, period, 3'b000} + {3'b000, period, 1'b0};
   assign target_x11 = {1'b0, target_period, 3'b000}
                     + {3'b000, target_period, 1'b0}
                     + {4'b0000, target_period};
   assign miss       = period_x10 > target_x11;

   // Apply the event to the statistics
   always_comb begin
      last_wake_in   = last_wake_ff;
      period_low_in  = period_low_ff;
      period_high_in = period_high_ff;
      misses_in      = misses_ff;
      executions_in  = executions_ff;
      exec_total_in  = exec_total_ff;
      exec_low_in    = exec_low_ff;
      exec_high_in   = exec_high_ff;
      if (cmd.update) begin
         case (func_ff)
            FUNC_START: begin
               if (last_wake_ff != '0) begin
                  if (period < period_low_ff) begin
                     period_low_in = period;
                  end
                  if (period > period_high_ff) begin
                     period_high_in = period;
                  end
                  if (miss) begin
                     misses_in = misses_ff + 1'b1;
                  end
               end
               last_wake_in = now_ff;
            end
            FUNC_END: begin
               if (start_ff != '0) begin
                  executions_in = executions_ff + 1'b1;
                  exec_total_in = exec_total_ff + {{(TIME_W-STAT_W){1'b0}}, run_time};
                  if (run_time < exec_low_ff) begin
                     exec_low_in = run_time;
                  end
                  if (run_time > exec_high_ff) begin
                     exec_high_in = run_time;
                  end
               end
            end
            FUNC_CLEAR: begin
               last_wake_in   = '0;
               period_low_in  = '1;
               period_high_in = '0;
               misses_in      = '0;
               executions_in  = '0;
               exec_total_in  = '0;
               exec_low_in    = '1;
               exec_high_in   = '0;
            end
            default: begin
               // Unused kind: statistics hold
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_wake_ff   <= '0;
         period_low_ff  <= '1;
         period_high_ff <= '0;
         misses_ff      <= '0;
         executions_ff  <= '0;
         exec_total_ff  <= '0;
         exec_low_ff    <= '1;
         exec_high_ff   <= '0;
      end else begin
         last_wake_ff   <= last_wake_in;
         period_low_ff  <= period_low_in;
         period_high_ff <= period_high_in;
         misses_ff      <= misses_in;
         executions_ff  <= executions_in;
         exec_total_ff  <= exec_total_in;
         exec_low_ff    <= exec_low_in;
         exec_high_ff   <= exec_high_in;
      end
   end

   // Two restoring division steps per cycle: total / executions
   assign rem_a   = {div_rem_ff, div_quo_ff[TIME_W-1]};
   assign sub_a   = rem_a - {1'b0, executions_ff};
   assign geq_a   = rem_a >= {1'b0, executions_ff};
   assign mid_rem = geq_a ? sub_a[STAT_W-1:0] : rem_a[STAT_W-1:0];
   assign mid_quo = {div_quo_ff[TIME_W-2:0], geq_a};

   assign rem_b    = {mid_rem, mid_quo[TIME_W-1]};
   assign sub_b    = rem_b - {1'b0, executions_ff};
   assign geq_b    = rem_b >= {1'b0, executions_ff};
   assign next_rem = geq_b ? sub_b[STAT_W-1:0] : rem_b[STAT_W-1:0];
   assign next_quo = {mid_quo[TIME_W-2:0], geq_b};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         div_rem_ff <= '0;
         div_quo_ff <= exec_total_ff;
      end else if (cmd.div_step) begin
         div_rem_ff <= next_rem;
         div_quo_ff <= next_quo;
      end
   end

   // Advance the step count; wraps back to zero on the last step
   always_ff @(posedge clock) begin
      if (reset || cmd.div_load) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   assign status.div_last = (div_cnt_ff == '1);

   // Derived figures
   assign exec_avg   = (executions_ff == '0) ? '0 : div_quo_ff[STAT_W-1:0];
   assign period_sum = period_low_ff + period_high_ff;
   assign period_avg = (executions_ff > {{(STAT_W-1){1'b0}}, 1'b1})
                     ? {1'b0, period_sum[STAT_W-1:1]} : '0;
   assign jitter     = period_high_ff - period_low_ff;

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {jitter, period_avg, period_high_ff, period_low_ff,
                         exec_avg, exec_high_ff, exec_low_ff, misses_ff,
                         executions_ff};
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

// File: sv/task_timing_monitor_core.sv
// Task timing monitor: period and execution-time statistics per event.
// After an item is accepted the block runs an update, a divider load, the divider
// steps at two quotient bits each and a result load; then the result is valid.
// Input is accepted only while idle, so a new item waits for the serial 64 by 32
// divider and the result load, and also while the previous result is still waiting to be taken.
// Reset (synchronous, active high) clears statistics and target_period.
`default_nettype none

module task_timing_monitor_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input items
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // now_time [63:0], run_start_time [127:64]
   input  wire logic [ttm_pkg::REQ_W-1:0]          req_tdata,
   // func [1:0]
   input  wire logic [ttm_pkg::FUNC_W-1:0]         req_tuser,
   // Result items
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // run_count, miss_count, exec_min, exec_max, exec_avg, period_min,
   // period_max, period_avg, jitter; 32 bits each from bit 0 up
   output logic      [ttm_pkg::RSP_W-1:0]          rsp_tdata,
   // Configuration
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [ttm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ttm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [ttm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready
);
   import ttm_pkg::*;

   logic [STAT_W-1:0] target_ff, target_in;
   ttm_cmd_type       cmd;
   ttm_status_type    status;

   // Register write and read
   assign csr_pready = 1'b1;

   always_comb begin
      target_in = target_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (csr_paddr == CSR_TARGET_ADDR)) begin
         target_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   assign csr_prdata = (csr_paddr == CSR_TARGET_ADDR) ? target_ff : '0;

   ttm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ttm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .target_period  (target_ff),
      .func           (req_tuser),
      .now_time       (req_tdata[TIME_W-1:0]),
      .run_start_time (req_tdata[REQ_W-1:TIME_W]),
      .rsp_data       (rsp_tdata)
   );

   // Block goes busy once an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input still ready after an item was accepted");

   // Average execution time is zero with no executions
   a_avg_zero_no_runs: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[31:0] == '0)) |-> (rsp_tdata[159:128] == '0))
      else $error("exec_avg nonzero with zero run_count");

   // Average period is zero below two executions
   a_pavg_zero_few_runs: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[31:1] == '0)) |-> (rsp_tdata[255:224] == '0))
      else $error("period_avg nonzero with run_count below two");

   // A fresh result appears only when the input side is idle
   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result raised while an item is in progress");

endmodule

`default_nettype wire

// File: tb/task_timing_monitor_core_tb.sv
// Self-checking testbench for task_timing_monitor_core: period, deadline-miss
// and execution-time statistics, checked item by item against a predictor or fixed values.
// Depends on ttm_pkg and the core only; stream handshakes and the APB port.
`timescale 1ns / 1ps

module task_timing_monitor_core_tb;
   import ttm_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_AT = 200;
   localparam int HOLD_CYCLES = 800;
   localparam int DRAIN_CYCLES = 40;

   // Statistics as reported after reset or a clear
   localparam logic [RSP_W-1:0] STATS_AT_RESET = {
      32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0};
   // One execution of wrapped length 0xFFFF_FFFE, no period yet
   localparam logic [RSP_W-1:0] STATS_ONE_LONG_RUN = {
      32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
      32'hFFFF_FFFE, 32'd0, 32'd1};

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // now_time [63:0], run_start_time [127:64]
   logic [REQ_W-1:0]      req_tdata = '0;
   // func [1:0]
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // run_count, miss_count, exec_min, exec_max, exec_avg, period_min,
   // period_max, period_avg, jitter; 32 bits each from bit 0 up
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   task_timing_monitor_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state, mirroring the block's registers
   logic [31:0] target_us;
   logic [63:0] wake_ts;
   logic [31:0] per_lo;
   logic [31:0] per_hi;
   logic [31:0] miss_cnt;
   logic [31:0] exec_cnt;
   logic [63:0] exec_sum;
   logic [31:0] exec_lo;
   logic [31:0] exec_hi;

   logic [RSP_W-1:0] stats_pending [$];
   int error_count = 0;
   int cycle_count = 0;
   bit send_calm = 1'b0;

   string stat_names [RSP_FIELDS] = '{"run_count", "miss_count", "exec_min", "exec_max",
      "exec_avg", "period_min", "period_max", "period_avg", "jitter"};

   typedef struct {
      logic [FUNC_W-1:0] fn;
      logic [63:0]       now;
      logic [63:0]       start;
      bit                typed;
      logic [RSP_W-1:0]  want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 24;
   localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] WIDE_T = 64'd4201 + 64'hFFFF_FFFF;

   // Directed items, run with target_period = 1000
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{FUNC_UNUSED, 64'd0,      64'd0,      1'b1, STATS_AT_RESET},
      '{FUNC_END,    64'd5,      64'd0,      1'b1, STATS_AT_RESET},
      '{FUNC_START,  64'd0,      64'd0,      1'b1, STATS_AT_RESET},
      '{FUNC_START,  64'd0,      64'd0,      1'b1, STATS_AT_RESET},
      '{FUNC_START,  64'd1000,   64'd0,      1'b0, '0},
      '{FUNC_START,  64'd2000,   64'd0,      1'b0, '0},
      '{FUNC_START,  64'd3100,   64'd0,      1'b0, '0},
      '{FUNC_START,  64'd4201,   64'd0,      1'b0, '0},
      '{FUNC_START,  WIDE_T,     64'd0,      1'b0, '0},
      '{FUNC_START,  WIDE_T + 64'h1_0000_0000, 64'd0, 1'b0, '0},
      '{FUNC_START,  ALL64,      64'd0,      1'b0, '0},
      '{FUNC_START,  64'd0,      64'd0,      1'b0, '0},
      '{FUNC_START,  64'd7,      64'd0,      1'b0, '0},
      '{FUNC_END,    64'd5000,   64'd4000,   1'b0, '0},
      '{FUNC_END,    ALL64,      64'd1,      1'b0, '0},
      '{FUNC_END,    64'd1,      ALL64,      1'b0, '0},
      '{FUNC_END,    64'd77,     64'd77,     1'b0, '0},
      '{FUNC_CLEAR,  64'd0,      64'd0,      1'b1, STATS_AT_RESET},
      '{FUNC_END,    ALL64,      64'd1,      1'b1, STATS_ONE_LONG_RUN},
      '{FUNC_END,    64'd0,      64'h8000_0000_0000_0001, 1'b0, '0},
      '{FUNC_START,  64'hAAAA_AAAA_AAAA_AAAA, ALL64, 1'b0, '0},
      '{FUNC_START,  64'h5555_5555_5555_5555, ALL64, 1'b0, '0},
      '{FUNC_UNUSED, ALL64,      ALL64,      1'b0, '0},
      '{FUNC_CLEAR,  ALL64,      ALL64,      1'b1, STATS_AT_RESET}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic void clear_stats();
      wake_ts = '0;
      per_lo = '1;
      per_hi = '0;
      miss_cnt = '0;
      exec_cnt = '0;
      exec_sum = '0;
      exec_lo = '1;
      exec_hi = '0;
   endfunction

   // Apply one event to the statistics and return the reported fields
   function automatic logic [RSP_W-1:0] advance_stats(input logic [FUNC_W-1:0] fn,
                                                      input logic [63:0] now,
                                                      input logic [63:0] start);
      logic [63:0] diff;
      logic [31:0] span;
      logic [63:0] quot;
      logic [31:0] eavg;
      logic [31:0] pavg;
      logic [31:0] psum;
      case (fn)
         FUNC_START: begin
            if (wake_ts != 64'd0) begin
               diff = now - wake_ts;
               span = diff[31:0];
               if (span < per_lo) per_lo = span;
               if (span > per_hi) per_hi = span;
               if (({32'd0, span} * 64'd10) > ({32'd0, target_us} * 64'd11))
                  miss_cnt = miss_cnt + 32'd1;
            end
            wake_ts = now;
         end
         FUNC_END: begin
            if (start != 64'd0) begin
               diff = now - start;
               span = diff[31:0];
               exec_cnt = exec_cnt + 32'd1;
               exec_sum = exec_sum + {32'd0, span};
               if (span < exec_lo) exec_lo = span;
               if (span > exec_hi) exec_hi = span;
            end
         end
         FUNC_CLEAR: begin
            clear_stats();
         end
         default: begin
         end
      endcase
      eavg = '0;
      pavg = '0;
      if (exec_cnt != 32'd0) begin
         quot = exec_sum / {32'd0, exec_cnt};
         eavg = quot[31:0];
      end
      if (exec_cnt > 32'd1) begin
         psum = per_lo + per_hi;
         pavg = {1'b0, psum[31:1]};
      end
      return {per_hi - per_lo, pavg, per_hi, per_lo, eavg, exec_hi, exec_lo,
              miss_cnt, exec_cnt};
   endfunction

   // Offer one item after a random gap; record its expectation on acceptance
   task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [63:0] now,
                            input logic [63:0] start, input bit typed,
                            input logic [RSP_W-1:0] want);
      int gap;
      logic [RSP_W-1:0] pred;
      if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 18);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {start, now};
      req_tuser <= fn;
      do @(posedge clock); while (!req_tready);
      pred = advance_stats(fn, now, start);
      stats_pending.push_back(typed ? want : pred);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (stats_pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write the target while idle, then read it back
   task automatic set_target(input logic [31:0] tgt);
      logic [CSR_DATA_W-1:0] rd;
      wait_idle();
      csr_access(1'b1, CSR_TARGET_ADDR, tgt, rd);
      target_us = tgt;
      csr_access(1'b0, CSR_TARGET_ADDR, '0, rd);
      if (rd !== tgt) begin
         $error("target_period: expected %0d, got %0d", tgt, rd);
         error_count++;
      end
   endtask

   // Mostly well-formed start/end pairs around a nominal period, plus noise
   task automatic run_phase(input logic [31:0] tgt, input int quota);
      logic [63:0] ts;
      logic [63:0] step;
      logic [63:0] rnd_now;
      logic [63:0] rnd_start;
      logic [31:0] nominal;
      logic [FUNC_W-1:0] fn;
      int done;
      int pick;
      set_target(tgt);
      if (tgt != 32'd0 && tgt < 32'h1000_0000) nominal = tgt;
      else nominal = $urandom_range(1, 200000);
      ts = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) ts = ALL64 - {32'd0, $urandom_range(0, 500000)};
      done = 0;
      while (done < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            fn = FUNC_W'($urandom_range(0, 3));
            rnd_now = {$urandom, $urandom};
            rnd_start = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
            send_item(fn, rnd_now, rnd_start, 1'b0, '0);
            if (fn == FUNC_START || fn == FUNC_CLEAR || (fn == FUNC_END && rnd_start != 0))
               done++;
         end else if (pick < 13) begin
            send_item(FUNC_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, '0);
            done++;
         end else begin
            send_item(FUNC_START, ts, {$urandom, $urandom}, 1'b0, '0);
            send_item(FUNC_END, ts + {32'd0, $urandom_range(0, nominal)}, ts, 1'b0, '0);
            done += 2;
            step = ({32'd0, nominal} * 64'($urandom_range(85, 125))) / 64'd100;
            if ($urandom_range(0, 19) == 0) step = {$urandom, $urandom};
            ts = ts + step;
         end
      end
   endtask

   // Result side: random stalls, one long hold-off to back the block up
   initial begin : rsp_sink
      int stall;
      int seen;
      bit calm;
      logic [RSP_W-1:0] want;
      seen = 0;
      calm = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 31) == 0) calm = !calm;
         stall = calm ? 0 : $urandom_range(0, 18);
         if (seen == HOLD_AT) stall = HOLD_CYCLES;
         @(negedge clock);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         seen++;
         if (stats_pending.size() == 0) begin
            $error("result item with no expectation waiting: %h", rsp_tdata);
            error_count++;
         end else begin
            want = stats_pending.pop_front();
            for (int f = 0; f < RSP_FIELDS; f++) begin
               if (rsp_tdata[f*STAT_W +: STAT_W] !== want[f*STAT_W +: STAT_W]) begin
                  $error("%s: expected %0d, got %0d", stat_names[f],
                         want[f*STAT_W +: STAT_W], rsp_tdata[f*STAT_W +: STAT_W]);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      target_us = '0;
      clear_stats();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_target(32'd1000);
      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_item(directed_rows[r].fn, directed_rows[r].now, directed_rows[r].start,
                   directed_rows[r].typed, directed_rows[r].want);

      run_phase(32'd0, 150);
      run_phase(32'hFFFF_FFFF, 150);
      run_phase($urandom_range(500, 50000), 150);
      run_phase($urandom, 150);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
